/* rtl/core/trr_pkg.sv */
// Shared types, constants and codes for the transport reassembly receiver.
package trr_pkg;

    localparam int SOURCE_SLOTS_DEF = 256;

    localparam logic [7:0] CODE_RTS   = 8'd16;
    localparam logic [7:0] CODE_BAM   = 8'd32;
    localparam logic [7:0] CODE_ABORT = 8'd255;
    localparam logic [7:0] BROADCAST  = 8'hFF;
    localparam logic [2:0] MAX_TAKE   = 3'd7;
    localparam logic [3:0] FULL_LEN   = 4'd8;

    localparam logic [1:0] RK_PAYLOAD = 2'd0;
    localparam logic [1:0] RK_CTS     = 2'd1;
    localparam logic [1:0] RK_EOM     = 2'd2;
    localparam logic [1:0] RK_DISCARD = 2'd3;

    localparam int IN_W  = 80;
    localparam int OUT_W = 136;

    typedef struct packed {
        logic [7:0]  next_pkt;
        logic [7:0]  total_pkts;
        logic [15:0] size_bytes;
        logic        is_rts;
    } sess_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  peer;
        logic [23:0] grp;
        logic [55:0] pay;
        logic [2:0]  cnt;
        logic        done;
        logic [7:0]  dest;
        logic [7:0]  pkt;
        logic [15:0] mbytes;
        logic [7:0]  mpkts;
    } res_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic load_res;
    } trr_cmd_t;

    typedef struct packed {
        logic [1:0] n_res;
    } trr_sts_t;

endpackage

/* rtl/core/transport_reassembly_receiver_core.sv */
// Top level of the transport reassembly receiver.
// A frame with a length code of eight or more is accepted in the idle state,
// then reads its session entry (one entry per source address) in the lookup
// state and updates the entry and forms up to two results in the execute
// state, followed by one transfer per result. Each transfer waits while the
// output holds off, and no new frame is accepted until the last one is taken.
// Frames with a shorter length code are accepted and dropped in the idle
// state, and they and frames without effect produce no transfer.
// Configuration writes to own_address are accepted at any time and should be
// made while no frame is in progress.
module transport_reassembly_receiver_core import trr_pkg::*; #(
    parameter int SOURCE_SLOTS = SOURCE_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // kind
    input  logic              s_tuser,
    // source_address[7:0], frame_length[11:8], frame_data[75:12], zero[79:76]
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // result_kind
    output logic [1:0]        m_tuser,
    // peer_address, group_number, payload_bytes, byte_count, message_done,
    // destination_address, packet_number, message_bytes, message_packets,
    // from bit 0 up, zero-filled to 136 bits
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    logic [7:0] own_reg;
    trr_cmd_t   cmd;
    trr_sts_t   sts;
    logic       res_sel, s_fire, in_ready;
    res_t       r;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) own_reg <= '0;
        else if (cfg_valid) own_reg <= cfg_data;
    end

    assign s_tready = in_ready;
    assign s_fire   = s_tvalid && in_ready && (s_tdata[11:8] >= FULL_LEN);

    trr_controller u_ctrl (
        .aclk, .aresetn, .in_fire(s_fire), .out_ready(m_tready), .sts, .cmd,
        .in_ready, .out_valid(m_tvalid), .out_last(m_tlast), .res_sel
    );

    trr_datapath #(.SOURCE_SLOTS(SOURCE_SLOTS)) u_dp (
        .aclk, .aresetn, .cmd, .sts, .in_kind(s_tuser), .in_data(s_tdata),
        .own_address(own_reg), .res_sel, .res_out(r)
    );

    assign m_tuser = r.kind;
    assign m_tdata = {4'd0, r.mpkts, r.mbytes, r.pkt, r.dest, r.done, r.cnt, r.pay,
                      r.grp, r.peer};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input accepted while results pending");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after last transfer");
endmodule

/* rtl/core/trr_datapath.sv */
// Session tables, frame decode and result formation for the receiver.
module trr_datapath import trr_pkg::*; #(
    parameter int SOURCE_SLOTS = SOURCE_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  trr_cmd_t           cmd,
    output trr_sts_t           sts,
    input  logic               in_kind,
    input  logic [IN_W-1:0]    in_data,
    input  logic [7:0]         own_address,
    input  logic               res_sel,
    output res_t               res_out
);
    localparam int AW = $clog2(SOURCE_SLOTS);

    logic              valid_reg [SOURCE_SLOTS];
    sess_t             ctl_mem   [SOURCE_SLOTS];
    logic [23:0]       grp_mem   [SOURCE_SLOTS];
    logic [15:0]       rcv_mem   [SOURCE_SLOTS];

    logic              kind_reg;
    logic [7:0]        src_reg;
    logic [63:0]       d_reg;
    sess_t             ctl_reg;
    logic [23:0]       grp_reg;
    logic [15:0]       rcv_reg;
    logic              live_reg;
    res_t              r0_reg, r1_reg;
    logic [1:0]        n_reg;

    logic [AW-1:0]     slot;
    assign slot = src_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            src_reg  <= in_data[7:0];
            d_reg    <= in_data[75:12];
        end
        if (cmd.lookup) begin
            ctl_reg <= ctl_mem[slot];
            grp_reg <= grp_mem[slot];
            rcv_reg <= rcv_mem[slot];
        end
    end

    logic [7:0]  code, seq, nxt1;
    logic        open_s, wr_ctl, wr_rcv, clr, set_v;
    sess_t       ctl_new;
    logic [23:0] grp_new;
    logic [15:0] rcv_new, rem;
    logic [2:0]  take;
    logic [55:0] mask;
    logic        done;
    logic [7:0]  dest;
    res_t        a, b, z;
    logic [1:0]  n;

    always_comb begin
        code = d_reg[7:0];
        seq  = d_reg[7:0];
        nxt1 = ctl_reg.next_pkt + 8'd1;
        dest = ctl_reg.is_rts ? own_address : BROADCAST;
        rem  = (ctl_reg.size_bytes > rcv_reg) ? ctl_reg.size_bytes - rcv_reg : 16'd0;
        take = (rem < 16'(MAX_TAKE)) ? rem[2:0] : MAX_TAKE;
        mask = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < take) mask[8*i +: 8] = 8'hFF;
        end
        rcv_new = rcv_reg + 16'(take);
        done    = rcv_new >= ctl_reg.size_bytes;
        z = '0;
        z.peer = src_reg;
        a = z; b = z; n = 2'd0;
        open_s = 1'b0; wr_ctl = 1'b0; wr_rcv = 1'b0; clr = 1'b0; set_v = 1'b0;
        ctl_new = ctl_reg; grp_new = grp_reg;
        if (!kind_reg) begin
            if (code == CODE_BAM || code == CODE_RTS || code == CODE_ABORT) begin
                if (live_reg) begin
                    a.kind = RK_DISCARD; a.grp = grp_reg; a.dest = dest; n = 2'd1;
                end
                if (code == CODE_ABORT) begin
                    clr = 1'b1;
                end else begin
                    open_s = 1'b1; wr_ctl = 1'b1; set_v = 1'b1;
                    ctl_new.is_rts      = (code == CODE_RTS);
                    ctl_new.size_bytes  = d_reg[23:8];
                    ctl_new.total_pkts  = d_reg[31:24];
                    ctl_new.next_pkt    = 8'd1;
                    grp_new = d_reg[63:40];
                    if (code == CODE_RTS) begin
                        b = z; b.kind = RK_CTS; b.grp = grp_new; b.dest = own_address;
                        b.pkt = 8'd1;
                        if (live_reg) n = 2'd2;
                        else begin a = b; n = 2'd1; end
                    end
                end
            end
        end else if (live_reg) begin
            if (seq != ctl_reg.next_pkt) begin
                if (ctl_reg.is_rts) begin
                    a.kind = RK_CTS; a.grp = grp_reg; a.dest = dest;
                    a.pkt = ctl_reg.next_pkt; n = 2'd1;
                end
            end else begin
                a.kind = RK_PAYLOAD; a.grp = grp_reg; a.dest = dest;
                a.pay = d_reg[63:8] & mask; a.cnt = take; a.done = done; n = 2'd1;
                b.grp = grp_reg; b.dest = dest;
                if (done) begin
                    clr = 1'b1;
                    b.kind = RK_EOM; b.mbytes = ctl_reg.size_bytes;
                    b.mpkts = ctl_reg.total_pkts;
                end else begin
                    wr_ctl = 1'b1; wr_rcv = 1'b1; ctl_new.next_pkt = nxt1;
                    b.kind = RK_CTS; b.pkt = nxt1;
                end
                if (ctl_reg.is_rts) n = 2'd2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (wr_ctl) ctl_mem[slot] <= ctl_new;
            if (open_s) begin
                grp_mem[slot] <= grp_new;
                rcv_mem[slot] <= '0;
            end else if (wr_rcv) begin
                rcv_mem[slot] <= rcv_new;
            end
        end
        if (cmd.load_res) begin
            r0_reg <= a;
            r1_reg <= b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SOURCE_SLOTS; i++) valid_reg[i] <= 1'b0;
            live_reg <= 1'b0;
            n_reg    <= '0;
        end else begin
            if (cmd.lookup) live_reg <= valid_reg[slot];
            if (cmd.update) begin
                if (set_v) valid_reg[slot] <= 1'b1;
                else if (clr) valid_reg[slot] <= 1'b0;
            end
            if (cmd.load_res) n_reg <= n;
        end
    end

    assign sts.n_res = cmd.load_res ? n : n_reg;
    assign res_out   = res_sel ? r1_reg : r0_reg;
endmodule

/* rtl/core/trr_controller.sv */
// Control state machine sequencing frame lookup, update and result transfers.
module trr_controller import trr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     out_ready,
    input  trr_sts_t sts,
    output trr_cmd_t cmd,
    output logic     in_ready,
    output logic     out_valid,
    output logic     out_last,
    output logic     res_sel
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic       sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.capture = in_fire;
        case (state_reg)
            S_IDLE: if (in_fire) state_next = S_LOOK;
            S_LOOK: begin
                cmd.lookup = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.update   = 1'b1;
                cmd.load_res = 1'b1;
                sel_next     = 1'b0;
                state_next   = (sts.n_res == 2'd0) ? S_IDLE : S_OUT;
            end
            S_OUT: if (out_ready) begin
                if (out_last) state_next = S_IDLE;
                else sel_next = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign res_sel   = sel_reg;
    assign out_last  = sel_reg || (sts.n_res == 2'd1);
endmodule
